FILE: src/mpzv_pkg.sv
// Shared types, constants and operation codes for the mouse pan and zoom viewport.
`default_nettype none
package mpzv_pkg;

  // Screen limits and the zoom-in and zoom-out offsets, in pixels.
  localparam int unsigned COL_MAX     = 639;
  localparam int unsigned ROW_MAX     = 479;
  localparam int unsigned COL_ZOOM_IN = 159;
  localparam int unsigned ROW_ZOOM_IN = 119;
  localparam int unsigned COL_CENTER  = 319;
  localparam int unsigned ROW_CENTER  = 239;

  localparam int unsigned MAX_ZOOM_DEF = 24;

  // Depth of the queue between the front and back parts.
  localparam int unsigned MID_DEPTH = 2;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_BASE_X_ORIGIN = 2'd0;
  localparam logic [1:0] REG_BASE_Y_ORIGIN = 2'd1;
  localparam logic [1:0] REG_BASE_X_PITCH  = 2'd2;
  localparam logic [1:0] REG_BASE_Y_PITCH  = 2'd3;

  // Register reset values.
  localparam logic [31:0] BASE_X_ORIGIN_RST = 32'hFF00_0000;
  localparam logic [31:0] BASE_Y_ORIGIN_RST = 32'hFF80_0000;
  localparam logic [30:0] BASE_X_PITCH_RST  = 31'd39383;
  localparam logic [30:0] BASE_Y_PITCH_RST  = 31'd35025;

  // Origin operations handed from the front part to the back part.
  localparam logic [1:0] OP_HOLD = 2'd0;
  localparam logic [1:0] OP_IN   = 2'd1;
  localparam logic [1:0] OP_OUT  = 2'd2;
  localparam logic [1:0] OP_BASE = 2'd3;

  typedef struct packed {
    logic              left_button;
    logic              right_button;
    logic signed [7:0] move_x;
    logic signed [7:0] move_y;
  } in_beat_t;

  typedef struct packed {
    logic [9:0]         cursor_x;
    logic [8:0]         cursor_y;
    logic signed [31:0] view_x_origin;
    logic signed [31:0] view_y_origin;
    logic [30:0]        view_x_pitch;
    logic [30:0]        view_y_pitch;
    logic [4:0]         zoom_depth;
  } out_beat_t;

  typedef struct packed {
    logic signed [31:0] base_x_origin;
    logic signed [31:0] base_y_origin;
    logic [30:0]        base_x_pitch;
    logic [30:0]        base_y_pitch;
  } cfg_regs_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [31:0] delta_x;
    logic [31:0] delta_y;
    logic [9:0]  col;
    logic [8:0]  row;
    logic [30:0] pitch_x;
    logic [30:0] pitch_y;
    logic [4:0]  level;
  } mid_entry_t;

endpackage
`default_nettype wire

FILE: src/mpzv_front.sv
// Front part: cursor and zoom level tracking, origin delta products.
`default_nettype none
module mpzv_front #(
  parameter int unsigned MAX_ZOOM = mpzv_pkg::MAX_ZOOM_DEF
) (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_push,
  output logic                 in_full,
  input  mpzv_pkg::in_beat_t   in_data,
  input  mpzv_pkg::cfg_regs_t  cfg,
  output logic                 wr_valid,
  input  wire                  wr_ready,
  output mpzv_pkg::mid_entry_t wr_data
);
  import mpzv_pkg::*;

  logic [9:0]  col_r, col_nxt;
  logic [8:0]  row_r, row_nxt;
  logic [4:0]  level_r, level_nxt;
  logic        s1_valid_r, s1_valid_nxt;
  logic [1:0]  s1_op_r, op_nxt;
  logic [31:0] s1_ax_r, s1_bx_r, s1_ay_r, s1_by_r;
  logic [9:0]  s1_col_r;
  logic [8:0]  s1_row_r;
  logic [4:0]  s1_level_r;
  logic [30:0] s1_px_r, s1_py_r;

  logic              accept;
  logic signed [11:0] col_sum, row_sum;
  logic [30:0] pitch_old_x, pitch_old_y, pitch_new_x, pitch_new_y;
  logic [9:0]  factor_x;
  logic [8:0]  factor_y;
  logic [40:0] prod_ax;
  logic [39:0] prod_ay;
  logic [39:0] prod_bx;
  logic [39:0] prod_by;

  assign in_full = s1_valid_r && !wr_ready;
  assign accept  = in_push && !in_full;

  always_comb begin
    col_sum = $signed({2'b00, col_r}) + $signed({{4{in_data.move_x[7]}}, in_data.move_x});
    row_sum = $signed({3'b000, row_r}) - $signed({{4{in_data.move_y[7]}}, in_data.move_y});
    if (col_sum < 0) begin
      col_nxt = '0;
    end else if (col_sum > $signed(12'(COL_MAX))) begin
      col_nxt = 10'(COL_MAX);
    end else begin
      col_nxt = col_sum[9:0];
    end
    if (row_sum < 0) begin
      row_nxt = '0;
    end else if (row_sum > $signed(12'(ROW_MAX))) begin
      row_nxt = 9'(ROW_MAX);
    end else begin
      row_nxt = row_sum[8:0];
    end

    // Left has priority; a right click at level zero does nothing.
    op_nxt    = OP_HOLD;
    level_nxt = level_r;
    if (in_data.left_button) begin
      if (level_r < 5'(MAX_ZOOM)) begin
        op_nxt    = OP_IN;
        level_nxt = level_r + 5'd1;
      end
    end else if (in_data.right_button && level_r != 5'd0) begin
      level_nxt = level_r - 5'd1;
      op_nxt    = (level_nxt == 5'd0) ? OP_BASE : OP_OUT;
    end

    pitch_old_x = cfg.base_x_pitch >> level_r;
    pitch_old_y = cfg.base_y_pitch >> level_r;
    pitch_new_x = cfg.base_x_pitch >> level_nxt;
    pitch_new_y = cfg.base_y_pitch >> level_nxt;

    if (op_nxt == OP_IN) begin
      factor_x = (col_nxt > 10'(COL_ZOOM_IN)) ? col_nxt - 10'(COL_ZOOM_IN) : '0;
      factor_y = (row_nxt > 9'(ROW_ZOOM_IN)) ? row_nxt - 9'(ROW_ZOOM_IN) : '0;
    end else begin
      factor_x = col_nxt;
      factor_y = row_nxt;
    end

    prod_ax = {31'b0, factor_x} * {10'b0, pitch_old_x};
    prod_ay = {31'b0, factor_y} * {9'b0, pitch_old_y};
    prod_bx = 40'(COL_CENTER) * {9'b0, pitch_new_x};
    prod_by = 40'(ROW_CENTER) * {9'b0, pitch_new_y};

    s1_valid_nxt = accept ? 1'b1 : (s1_valid_r && !wr_ready);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= 10'(COL_CENTER);
      row_r      <= 9'(ROW_CENTER);
      level_r    <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
      if (accept) begin
        col_r   <= col_nxt;
        row_r   <= row_nxt;
        level_r <= level_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r    <= op_nxt;
      s1_ax_r    <= prod_ax[31:0];
      s1_ay_r    <= prod_ay[31:0];
      s1_bx_r    <= (op_nxt == OP_OUT) ? prod_bx[31:0] : '0;
      s1_by_r    <= (op_nxt == OP_OUT) ? prod_by[31:0] : '0;
      s1_col_r   <= col_nxt;
      s1_row_r   <= row_nxt;
      s1_level_r <= level_nxt;
      s1_px_r    <= pitch_new_x;
      s1_py_r    <= pitch_new_y;
    end
  end

  assign wr_valid = s1_valid_r;

  always_comb begin
    wr_data.op      = s1_op_r;
    wr_data.delta_x = s1_ax_r - s1_bx_r;
    wr_data.delta_y = s1_ay_r - s1_by_r;
    wr_data.col     = s1_col_r;
    wr_data.row     = s1_row_r;
    wr_data.pitch_x = s1_px_r;
    wr_data.pitch_y = s1_py_r;
    wr_data.level   = s1_level_r;
  end

endmodule
`default_nettype wire

FILE: src/mpzv_fifo.sv
// Short queue that decouples the front part from the back part.
`default_nettype none
module mpzv_fifo (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  wr_valid,
  output logic                 wr_ready,
  input  mpzv_pkg::mid_entry_t wr_data,
  output logic                 rd_valid,
  input  wire                  rd_ready,
  output mpzv_pkg::mid_entry_t rd_data
);
  import mpzv_pkg::*;

  localparam int unsigned PW = (MID_DEPTH > 1) ? $clog2(MID_DEPTH) : 1;
  localparam int unsigned CW = $clog2(MID_DEPTH + 1);

  mid_entry_t    mem_r [MID_DEPTH];
  logic [PW-1:0] wr_ptr_r, rd_ptr_r;
  logic [CW-1:0] count_r;
  logic          do_wr, do_rd;

  assign wr_ready = (count_r != CW'(MID_DEPTH));
  assign rd_valid = (count_r != '0);
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;
  assign rd_data  = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= (wr_ptr_r == PW'(MID_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_r <= (rd_ptr_r == PW'(MID_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + 1'b1;
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_data;
    end
  end

endmodule
`default_nettype wire

FILE: src/mpzv_back.sv
// Back part: view origin update and the result register.
`default_nettype none
module mpzv_back (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  rd_valid,
  output logic                 rd_ready,
  input  mpzv_pkg::mid_entry_t rd_data,
  input  mpzv_pkg::cfg_regs_t  cfg,
  output logic                 out_empty,
  input  wire                  out_pop,
  output mpzv_pkg::out_beat_t  out_data
);
  import mpzv_pkg::*;

  logic signed [31:0] origin_x_r, origin_x_nxt;
  logic signed [31:0] origin_y_r, origin_y_nxt;
  logic signed [31:0] sum_x, sum_y;
  logic               out_valid_r, out_valid_nxt;
  out_beat_t          out_r;
  logic               advance;

  assign rd_ready  = !out_valid_r || out_pop;
  assign advance   = rd_valid && rd_ready;
  assign out_empty = !out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    sum_x = origin_x_r + $signed(rd_data.delta_x);
    sum_y = origin_y_r + $signed(rd_data.delta_y);
    unique case (rd_data.op)
      OP_HOLD: begin
        origin_x_nxt = origin_x_r;
        origin_y_nxt = origin_y_r;
      end
      OP_IN: begin
        origin_x_nxt = sum_x;
        origin_y_nxt = sum_y;
      end
      OP_OUT: begin
        origin_x_nxt = (sum_x < cfg.base_x_origin) ? cfg.base_x_origin : sum_x;
        origin_y_nxt = (sum_y < cfg.base_y_origin) ? cfg.base_y_origin : sum_y;
      end
      OP_BASE: begin
        origin_x_nxt = cfg.base_x_origin;
        origin_y_nxt = cfg.base_y_origin;
      end
      default: begin
        origin_x_nxt = origin_x_r;
        origin_y_nxt = origin_y_r;
      end
    endcase
    out_valid_nxt = advance ? 1'b1 : (out_valid_r && !out_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      origin_x_r  <= BASE_X_ORIGIN_RST;
      origin_y_r  <= BASE_Y_ORIGIN_RST;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        origin_x_r <= origin_x_nxt;
        origin_y_r <= origin_y_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_r.cursor_x      <= rd_data.col;
      out_r.cursor_y      <= rd_data.row;
      out_r.view_x_origin <= origin_x_nxt;
      out_r.view_y_origin <= origin_y_nxt;
      out_r.view_x_pitch  <= rd_data.pitch_x;
      out_r.view_y_pitch  <= rd_data.pitch_y;
      out_r.zoom_depth    <= rd_data.level;
    end
  end

endmodule
`default_nettype wire

FILE: src/mouse_pan_zoom_viewport.sv
// Top level of the mouse pan and zoom viewport with its configuration registers.
//
// Each mouse beat pushed in yields exactly one result beat: the clamped cursor
// (0..639 by 0..479, y motion subtracted), the view origin, the per-pixel pitch
// (base pitch shifted right by the zoom level) and the level itself. A left
// click zooms in one level up to MAX_ZOOM, a right click above level zero zooms
// out around the cursor. The block takes one beat per clock cycle while the
// result side keeps popping. A beat's result passes through the front product
// register, then the queue, then the result register before it shows on the
// result ports. The front part tracks cursor and level and forms the origin
// offsets with two multipliers per axis; the back part applies them to the
// origin with one add and signed compare per axis, so the origin recurrence
// closes through the origin register alone. A two-entry queue between them
// and a result register let input and output stall independently.
// Configuration writes are always ready, take effect the next cycle, and should
// be made only while no beat is in flight; they never move the stored origin.
`default_nettype none
module mouse_pan_zoom_viewport #(
  parameter int unsigned MAX_ZOOM = mpzv_pkg::MAX_ZOOM_DEF
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_push,
  output logic                in_full,
  input  mpzv_pkg::in_beat_t  in_data,
  output logic                out_empty,
  input  wire                 out_pop,
  output mpzv_pkg::out_beat_t out_data,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire [1:0]           cfg_index,
  input  wire [31:0]          cfg_data
);
  import mpzv_pkg::*;

  cfg_regs_t  cfg_r;
  mid_entry_t wr_data, rd_data;
  logic       wr_valid, wr_ready, rd_valid, rd_ready;

  // The register file never stalls a write.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_x_origin <= BASE_X_ORIGIN_RST;
      cfg_r.base_y_origin <= BASE_Y_ORIGIN_RST;
      cfg_r.base_x_pitch  <= BASE_X_PITCH_RST;
      cfg_r.base_y_pitch  <= BASE_Y_PITCH_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BASE_X_ORIGIN: cfg_r.base_x_origin <= cfg_data;
        REG_BASE_Y_ORIGIN: cfg_r.base_y_origin <= cfg_data;
        REG_BASE_X_PITCH:  cfg_r.base_x_pitch  <= cfg_data[30:0];
        REG_BASE_Y_PITCH:  cfg_r.base_y_pitch  <= cfg_data[30:0];
        default: begin
        end
      endcase
    end
  end

  // Front part: accepts mouse beats, moves the cursor and decides the zoom step.
  mpzv_front #(
    .MAX_ZOOM (MAX_ZOOM)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_data  (in_data),
    .cfg      (cfg_r),
    .wr_valid (wr_valid),
    .wr_ready (wr_ready),
    .wr_data  (wr_data)
  );

  mpzv_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (wr_valid),
    .wr_ready (wr_ready),
    .wr_data  (wr_data),
    .rd_valid (rd_valid),
    .rd_ready (rd_ready),
    .rd_data  (rd_data)
  );

  // Back part: owns the view origin and the result register.
  mpzv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_valid  (rd_valid),
    .rd_ready  (rd_ready),
    .rd_data   (rd_data),
    .cfg       (cfg_r),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule
`default_nettype wire

FILE: sim/view_checker.sv
// Checker for the mouse pan and zoom viewport: watches all three channels and predicts results.
module view_checker #(
  parameter int unsigned MAX_ZOOM = mpzv_pkg::MAX_ZOOM_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  input  logic                in_full,
  input  mpzv_pkg::in_beat_t  in_data,
  input  logic                out_empty,
  input  logic                out_pop,
  input  mpzv_pkg::out_beat_t out_data,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [31:0]         cfg_data,
  output int                  fail_count,
  output int                  pending,
  output int                  checked,
  output int                  deepest,
  output int                  limit_hits
);
  import mpzv_pkg::*;

  // Mirror of the block's registers and view state.
  logic [31:0] base_xo, base_yo;
  logic [30:0] base_xp, base_yp;
  logic [9:0]  cur_col;
  logic [8:0]  cur_row;
  logic [4:0]  cur_level;
  logic [31:0] org_x, org_y;

  out_beat_t expected_views[$];

  // Applies one mouse beat to the mirrored state and returns the view it should produce.
  function automatic out_beat_t advance_view(input in_beat_t b);
    int          col_t, row_t;
    logic [31:0] pitch_x, pitch_y, off_x, off_y, pos_x, pos_y;
    out_beat_t   r;
    col_t = int'(cur_col) + int'($signed(b.move_x));
    row_t = int'(cur_row) - int'($signed(b.move_y));
    cur_col = (col_t < 0) ? '0 : (col_t > int'(COL_MAX)) ? 10'(COL_MAX) : 10'(col_t);
    cur_row = (row_t < 0) ? '0 : (row_t > int'(ROW_MAX)) ? 9'(ROW_MAX) : 9'(row_t);
    pitch_x = {1'b0, base_xp >> cur_level};
    pitch_y = {1'b0, base_yp >> cur_level};
    if (b.left_button) begin
      if (cur_level < MAX_ZOOM) begin
        off_x = (cur_col > COL_ZOOM_IN) ? 32'(cur_col) - COL_ZOOM_IN : '0;
        off_y = (cur_row > ROW_ZOOM_IN) ? 32'(cur_row) - ROW_ZOOM_IN : '0;
        org_x = org_x + off_x * pitch_x;
        org_y = org_y + off_y * pitch_y;
        cur_level = cur_level + 1'b1;
      end else begin
        limit_hits++;
      end
    end else if (b.right_button && cur_level != 0) begin
      // The point under the cursor is found at the old pitch, the new origin at the new one.
      pos_x = org_x + 32'(cur_col) * pitch_x;
      pos_y = org_y + 32'(cur_row) * pitch_y;
      cur_level = cur_level - 1'b1;
      pitch_x = {1'b0, base_xp >> cur_level};
      pitch_y = {1'b0, base_yp >> cur_level};
      org_x = pos_x - COL_CENTER * pitch_x;
      org_y = pos_y - ROW_CENTER * pitch_y;
      if ($signed(org_x) < $signed(base_xo)) org_x = base_xo;
      if ($signed(org_y) < $signed(base_yo)) org_y = base_yo;
      if (cur_level == 0) begin
        org_x = base_xo;
        org_y = base_yo;
      end
    end
    if (int'(cur_level) > deepest) deepest = int'(cur_level);
    r.cursor_x      = cur_col;
    r.cursor_y      = cur_row;
    r.view_x_origin = org_x;
    r.view_y_origin = org_y;
    r.view_x_pitch  = base_xp >> cur_level;
    r.view_y_pitch  = base_yp >> cur_level;
    r.zoom_depth    = cur_level;
    return r;
  endfunction

  task automatic cmp_field(input string label, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, label, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : monitor
    out_beat_t want;
    if (!rst_n) begin
      base_xo    = BASE_X_ORIGIN_RST;
      base_yo    = BASE_Y_ORIGIN_RST;
      base_xp    = BASE_X_PITCH_RST;
      base_yp    = BASE_Y_PITCH_RST;
      cur_col    = 10'(COL_CENTER);
      cur_row    = 9'(ROW_CENTER);
      cur_level  = '0;
      org_x      = BASE_X_ORIGIN_RST;
      org_y      = BASE_Y_ORIGIN_RST;
      fail_count = 0;
      pending    = 0;
      checked    = 0;
      deepest    = 0;
      limit_hits = 0;
      expected_views.delete();
    end else begin
      // A result never leaves in the cycle its beat enters, so compare before predicting.
      if (out_pop && !out_empty) begin
        if (expected_views.size() == 0) begin
          $display("%0t: result beat with none expected, expected nothing, actual %h",
                   $time, out_data);
          fail_count++;
        end else begin
          want = expected_views.pop_front();
          cmp_field("cursor_x", 32'(want.cursor_x), 32'(out_data.cursor_x));
          cmp_field("cursor_y", 32'(want.cursor_y), 32'(out_data.cursor_y));
          cmp_field("view_x_origin", want.view_x_origin, out_data.view_x_origin);
          cmp_field("view_y_origin", want.view_y_origin, out_data.view_y_origin);
          cmp_field("view_x_pitch", 32'(want.view_x_pitch), 32'(out_data.view_x_pitch));
          cmp_field("view_y_pitch", 32'(want.view_y_pitch), 32'(out_data.view_y_pitch));
          cmp_field("zoom_depth", 32'(want.zoom_depth), 32'(out_data.zoom_depth));
          checked++;
        end
      end
      if (in_push && !in_full) expected_views.push_back(advance_view(in_data));
      // Register writes take effect after this edge.
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_BASE_X_ORIGIN: base_xo = cfg_data;
          REG_BASE_Y_ORIGIN: base_yo = cfg_data;
          REG_BASE_X_PITCH:  base_xp = cfg_data[30:0];
          REG_BASE_Y_PITCH:  base_yp = cfg_data[30:0];
          default: ;
        endcase
      end
      pending = expected_views.size();
    end
  end

endmodule

FILE: sim/tb_top.sv
// Top of the mouse pan and zoom viewport testbench: clock, reset, stimulus and verdict.
module tb_top;
  import mpzv_pkg::*;

  localparam int unsigned ZOOM_LIMIT   = MAX_ZOOM_DEF;
  localparam int          PHASES       = 8;
  localparam int          PHASE_BEATS  = 160;

  // Click mixes for the random part. A dive mostly zooms in, a climb mostly
  // zooms out, a pan mostly moves the cursor, and a mix does a bit of each.
  typedef enum int {G_MIX, G_DIVE, G_CLIMB, G_PAN} gesture_e;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_push   = 1'b0;
  logic        in_full;
  in_beat_t    in_data   = '0;
  logic        out_empty;
  logic        out_pop   = 1'b0;
  out_beat_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = REG_BASE_X_ORIGIN;
  logic [31:0] cfg_data  = '0;

  int fail_count, pending, checked, deepest, limit_hits;
  int beats_sent = 0;

  // Each side idles between beats only while its lazy flag is set, so the run
  // alternates stretches of random gaps with back-to-back traffic.
  bit feed_lazy  = 1'b1;
  bit drain_lazy = 1'b1;

  always #5 clk = ~clk;

  mouse_pan_zoom_viewport #(
    .MAX_ZOOM(ZOOM_LIMIT)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_data   (in_data),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  view_checker #(
    .MAX_ZOOM(ZOOM_LIMIT)
  ) checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_push    (in_push),
    .in_full    (in_full),
    .in_data    (in_data),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending),
    .checked    (checked),
    .deepest    (deepest),
    .limit_hits (limit_hits)
  );

  // Hard stop. The slowest legal run, with every beat waiting out both the
  // longest sender gap and the longest receiver stall, stays well below this.
  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic in_beat_t mk_beat(input bit l, input bit r,
                                       input logic [7:0] mx, input logic [7:0] my);
    in_beat_t b;
    b.left_button  = l;
    b.right_button = r;
    b.move_x       = mx;
    b.move_y       = my;
    return b;
  endfunction

  // Motion values: a quarter fully random so every bit toggles, a quarter
  // pinned to the extremes and the unit steps, the rest small drifts.
  function automatic logic [7:0] draw_move();
    int pick;
    pick = $urandom_range(0, 3);
    case (pick)
      0: return 8'($urandom_range(0, 255));
      1: begin
        case ($urandom_range(0, 4))
          0: return 8'sd127;
          1: return -8'sd128;
          2: return 8'sd1;
          3: return -8'sd1;
          default: return 8'sd0;
        endcase
      end
      default: return 8'($urandom_range(0, 16) - 8);
    endcase
  endfunction

  function automatic in_beat_t draw_beat(input gesture_e g);
    int roll;
    bit l, r;
    roll = $urandom_range(0, 99);
    case (g)
      G_DIVE: begin
        l = roll < 80;
        r = roll >= 70 && roll < 90;
      end
      G_CLIMB: begin
        r = roll < 75;
        l = roll >= 90;
      end
      G_PAN: begin
        l = roll < 5;
        r = roll >= 95;
      end
      default: begin
        l = roll < 30;
        r = roll >= 20 && roll < 55;
      end
    endcase
    return mk_beat(l, r, draw_move(), draw_move());
  endfunction

  // Called at a falling edge. Push stays high from one beat to the next when
  // there is no gap, so it is only lowered when a gap is actually drawn.
  task automatic send_beat(input in_beat_t b);
    int gap;
    gap = feed_lazy ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      in_push <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_push <= 1'b1;
    in_data <= b;
    do @(posedge clk); while (in_full);
    beats_sent++;
    @(negedge clk);
  endtask

  // Stops feeding, lets every expected result drain, and then idles on so
  // the pipeline is fully quiet before the registers change.
  task automatic wait_idle();
    in_push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Valid is left high between back-to-back writes; the caller lowers it.
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
  endtask

  // One register setting per phase: the first phase runs on reset values, the
  // next two pin origins and pitches to extremes, the third to zero and one, the
  // rest are random. Pitch data sometimes carries bit 31, which must be dropped.
  task automatic program_view(input int p);
    case (p)
      1: begin
        write_reg(REG_BASE_X_ORIGIN, 32'h8000_0000);
        write_reg(REG_BASE_Y_ORIGIN, 32'h7FFF_FFFF);
        write_reg(REG_BASE_X_PITCH,  32'h7FFF_FFFF);
        write_reg(REG_BASE_Y_PITCH,  32'h0000_0000);
      end
      2: begin
        write_reg(REG_BASE_X_ORIGIN, 32'h7FFF_FFFF);
        write_reg(REG_BASE_Y_ORIGIN, 32'h8000_0000);
        write_reg(REG_BASE_X_PITCH,  32'h0000_0000);
        write_reg(REG_BASE_Y_PITCH,  32'hFFFF_FFFF);
      end
      3: begin
        write_reg(REG_BASE_X_ORIGIN, 32'h0000_0000);
        write_reg(REG_BASE_Y_ORIGIN, 32'h0000_0000);
        write_reg(REG_BASE_X_PITCH,  32'h0000_0001);
        write_reg(REG_BASE_Y_PITCH,  32'h0000_0001);
      end
      default: begin
        write_reg(REG_BASE_X_ORIGIN, $urandom);
        write_reg(REG_BASE_Y_ORIGIN, $urandom);
        write_reg(REG_BASE_X_PITCH,  $urandom >> $urandom_range(0, 31));
        write_reg(REG_BASE_Y_PITCH,  $urandom >> $urandom_range(0, 31));
      end
    endcase
    cfg_valid <= 1'b0;
  endtask

  // Zooms all the way in, keeps clicking at the limit (left alone and both
  // buttons together), then zooms all the way out and clicks right once more
  // at level zero. Works from whatever level the view is at.
  task automatic full_dive();
    repeat (ZOOM_LIMIT + 2) send_beat(mk_beat(1'b1, 1'b0, draw_move(), draw_move()));
    send_beat(mk_beat(1'b1, 1'b1, draw_move(), draw_move()));
    repeat (ZOOM_LIMIT + 1) send_beat(mk_beat(1'b0, 1'b1, draw_move(), draw_move()));
  endtask

  // Result side: a random stall before each beat is taken, none while the
  // drain side is in a busy stretch.
  initial begin : drain
    int stall;
    wait (rst_n);
    @(negedge clk);
    forever begin
      stall = drain_lazy ? $urandom_range(0, 13) : 0;
      if (stall > 0) begin
        out_pop <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_pop <= 1'b1;
      do @(posedge clk); while (out_empty);
      @(negedge clk);
    end
  end

  initial begin : stimulus
    int       left;
    int       seg;
    gesture_e g;

    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed walk on the reset registers. The cursor starts at the screen
    // center, is driven into every edge, and the clicks cover zoom in, both
    // buttons, zoom out back to level zero and right clicks at level zero.
    send_beat(mk_beat(1'b0, 1'b0, 8'sd0, 8'sd0));
    send_beat(mk_beat(1'b0, 1'b1, 8'sd0, 8'sd0));       // right at level zero
    send_beat(mk_beat(1'b0, 1'b0, 8'sd127, -8'sd128));
    send_beat(mk_beat(1'b0, 1'b0, 8'sd127, -8'sd128));  // bottom edge
    send_beat(mk_beat(1'b0, 1'b0, 8'sd127, 8'sd127));   // right edge
    send_beat(mk_beat(1'b1, 1'b0, -8'sd128, 8'sd0));
    send_beat(mk_beat(1'b1, 1'b0, 8'sd0, 8'sd0));
    send_beat(mk_beat(1'b1, 1'b1, 8'sd0, 8'sd0));       // left wins over right
    send_beat(mk_beat(1'b0, 1'b1, -8'sd128, 8'sd0));
    send_beat(mk_beat(1'b0, 1'b0, -8'sd128, 8'sd127));
    send_beat(mk_beat(1'b0, 1'b0, -8'sd128, 8'sd127));
    send_beat(mk_beat(1'b0, 1'b0, -8'sd128, 8'sd127));  // top left corner
    send_beat(mk_beat(1'b1, 1'b0, 8'sd0, 8'sd0));       // zoom offsets floored
    send_beat(mk_beat(1'b0, 1'b1, 8'sd0, 8'sd0));       // zoom out at the top left corner
    send_beat(mk_beat(1'b0, 1'b1, 8'sd0, 8'sd0));
    send_beat(mk_beat(1'b0, 1'b1, 8'sd0, 8'sd0));       // back to the base origin
    send_beat(mk_beat(1'b0, 1'b1, -8'sd1, -8'sd1));
    send_beat(mk_beat(1'b1, 1'b1, 8'sd0, 8'sd0));
    send_beat(mk_beat(1'b0, 1'b0, 8'sh55, 8'shAA));
    send_beat(mk_beat(1'b0, 1'b1, 8'shAA, 8'sh55));

    for (int p = 0; p < PHASES; p++) begin
      if (p > 0) begin
        wait_idle();
        program_view(p);
      end
      if (p == 1 || p == 5) full_dive();
      // Random part in segments, each with its own click mix and idling.
      left = PHASE_BEATS;
      while (left > 0) begin
        seg = $urandom_range(10, 40);
        if (seg > left) seg = left;
        g          = gesture_e'($urandom_range(0, 3));
        feed_lazy  = ($urandom_range(0, 2) != 0);
        drain_lazy = ($urandom_range(0, 2) != 0);
        repeat (seg) send_beat(draw_beat(g));
        left -= seg;
      end
    end

    // Drain, then idle on so the block can show any stray beat.
    in_push <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("Sent %0d mouse beats under %0d register settings; %0d results compared.",
             beats_sent, PHASES, checked);
    $display("Deepest zoom level %0d; %0d zoom-in clicks landed at the limit.",
             deepest, limit_hits);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: mouse_pan_zoom_viewport.f
src/mpzv_pkg.sv
src/mpzv_front.sv
src/mpzv_fifo.sv
src/mpzv_back.sv
src/mouse_pan_zoom_viewport.sv
sim/view_checker.sv
sim/tb_top.sv
